// ===== src/two_level_page_table_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the two-level page table engine
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_PAGE_TABLE_ENGINE_ASSERT_SVH
`define TWO_LEVEL_PAGE_TABLE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define TLPTE_ASSERT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define TLPTE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define TLPTE_ASSERT(lbl, clk, rst, ante, cons)
`define TLPTE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== src/tlpte_pkg.sv =====
// ----------------------------------------------------------------------------
// Page table engine package
// Sizes, codes and transaction types shared by the engine's modules.
// ----------------------------------------------------------------------------
package tlpte_pkg;

   localparam int TABLE_COUNT = 16;

   localparam int ADDR_W      = 32;
   localparam int KIND_W      = 2;
   localparam int FLAG_W      = 3;
   localparam int STATUS_W    = 2;
   localparam int PAGE_SHIFT  = 12;
   localparam int OFFSET_W    = PAGE_SHIFT;
   localparam int FRAME_W     = ADDR_W - PAGE_SHIFT;
   localparam int DIR_ENTRIES = 1024;
   localparam int TBL_ENTRIES = 1024;
   localparam int DIR_AW      = $clog2(DIR_ENTRIES);
   localparam int TBL_AW      = $clog2(TBL_ENTRIES);
   localparam int TIDX_W      = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
   localparam int FREE_W      = $clog2(TABLE_COUNT + 1);
   localparam int POOL_DEPTH  = TABLE_COUNT * TBL_ENTRIES;
   localparam int POOL_AW     = $clog2(POOL_DEPTH);

   // two-entry queues, pointers wrap naturally
   localparam int Q_DEPTH     = 2;
   localparam int QPTR_W      = $clog2(Q_DEPTH);
   localparam int QCNT_W      = $clog2(Q_DEPTH + 1);

   typedef enum logic [KIND_W-1:0] {
      KIND_MAP   = 2'd0,
      KIND_UNMAP = 2'd1,
      KIND_XLATE = 2'd2,
      KIND_NONE  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE       = 2'd0,
      STATUS_NO_TABLE   = 2'd1,
      STATUS_NOT_MAPPED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      WS_CLEAR,
      WS_IDLE,
      WS_EXEC,
      WS_POOL
   } walk_state_type;

   typedef struct packed {
      op_type              op;
      logic [DIR_AW-1:0]   dir_idx;
      logic [TBL_AW-1:0]   tbl_idx;
      logic [OFFSET_W-1:0] offset;
      logic [FRAME_W-1:0]  frame;
      logic [FLAG_W-1:0]   flags;
   } cmd_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              mapped;
      status_type        status;
   } rsp_type;

endpackage

// ===== src/tlpte_front.sv =====
// ----------------------------------------------------------------------------
// Request front end
// Accepts request transactions, decodes them into commands and holds them
// in a two-entry queue for the walker.
// ----------------------------------------------------------------------------
module tlpte_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [tlpte_pkg::KIND_W-1:0]  req_kind,
   input  logic [tlpte_pkg::ADDR_W-1:0]  req_virtual_addr,
   input  logic [tlpte_pkg::ADDR_W-1:0]  req_physical_addr,
   input  logic [tlpte_pkg::FLAG_W-1:0]  req_page_flags,
   input  logic                          init_done,
   output logic                          cmd_valid,
   input  logic                          cmd_pop,
   output tlpte_pkg::cmd_type            cmd
);
   import tlpte_pkg::*;

   cmd_type             q_ff [Q_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   cmd_type             cmd_in;
   logic                push;
   logic                pop;

   // split the address into directory index, table index and offset
   always_comb begin
      cmd_in.op      = op_type'(req_kind);
      cmd_in.dir_idx = req_virtual_addr[ADDR_W-1 -: DIR_AW];
      cmd_in.tbl_idx = req_virtual_addr[PAGE_SHIFT +: TBL_AW];
      cmd_in.offset  = req_virtual_addr[OFFSET_W-1:0];
      cmd_in.frame   = req_physical_addr[ADDR_W-1:PAGE_SHIFT];
      cmd_in.flags   = req_page_flags;
   end

   assign req_full  = !init_done || (count_ff == QCNT_W'(Q_DEPTH));
   assign push      = req_push && !req_full;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// ===== src/tlpte_walker.sv =====
// ----------------------------------------------------------------------------
// Page table walker
// Owns the page directory and the table pool, clears both after reset and
// carries out one map, unmap or translate command at a time.
// ----------------------------------------------------------------------------
`include "two_level_page_table_engine_assert.svh"

module tlpte_walker (
   input  logic                clock,
   input  logic                reset,
   output logic                init_done,
   input  logic                cmd_valid,
   input  tlpte_pkg::cmd_type  cmd,
   output logic                cmd_pop,
   input  logic                rsp_full,
   output logic                rsp_push,
   output tlpte_pkg::rsp_type  rsp
);
   import tlpte_pkg::*;

   typedef struct packed {
      logic [TIDX_W-1:0] tidx;
      logic              user;
      logic              writable;
      logic              present;
   } dir_entry_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic [FLAG_W-1:0]  flags;
   } pte_type;

   dir_entry_type       dir_mem  [DIR_ENTRIES];
   pte_type             pool_mem [POOL_DEPTH];

   walk_state_type      state_ff, state_in;
   logic [POOL_AW-1:0]  clr_ff, clr_in;
   cmd_type             cur_ff, cur_in;
   logic [FREE_W-1:0]   next_free_ff, next_free_in;
   dir_entry_type       dir_rd_ff;
   pte_type             pool_rd_ff;

   logic                dir_we;
   logic [DIR_AW-1:0]   dir_waddr;
   logic [DIR_AW-1:0]   dir_raddr;
   dir_entry_type       dir_wdata;
   logic                pool_we;
   logic [POOL_AW-1:0]  pool_addr;
   pte_type             pool_wdata;

   function automatic logic [POOL_AW-1:0] pool_slot(input logic [TIDX_W-1:0] tidx,
                                                    input logic [TBL_AW-1:0] tbl_idx);
      return POOL_AW'({tidx, tbl_idx});
   endfunction

   assign init_done = (state_ff != WS_CLEAR);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      next_free_in = next_free_ff;
      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      rsp.addr     = '0;
      rsp.mapped   = 1'b0;
      rsp.status   = STATUS_DONE;
      dir_we       = 1'b0;
      dir_waddr    = cur_ff.dir_idx;
      dir_raddr    = cmd.dir_idx;
      dir_wdata    = '0;
      pool_we      = 1'b0;
      pool_addr    = pool_slot(dir_rd_ff.tidx, cur_ff.tbl_idx);
      pool_wdata   = '0;

      unique case (state_ff)
         WS_CLEAR: begin
            // sweep both stores, one entry a cycle
            dir_we     = (32'(clr_ff) < DIR_ENTRIES);
            dir_waddr  = clr_ff[DIR_AW-1:0];
            pool_we    = 1'b1;
            pool_addr  = clr_ff;
            if (clr_ff == POOL_AW'(POOL_DEPTH - 1)) begin
               state_in = WS_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         WS_IDLE: begin
            // hold off until the result queue has room for this command
            if (cmd_valid && !rsp_full) begin
               cmd_pop  = 1'b1;
               cur_in   = cmd;
               state_in = WS_EXEC;
            end
         end

         WS_EXEC: begin
            state_in = WS_IDLE;
            unique case (cur_ff.op)
               KIND_MAP: begin
                  rsp_push = 1'b1;
                  pool_wdata.frame = cur_ff.frame;
                  pool_wdata.flags = cur_ff.flags;
                  if (dir_rd_ff.present) begin
                     pool_we = 1'b1;
                  end else if (next_free_ff >= FREE_W'(TABLE_COUNT)) begin
                     rsp.status = STATUS_NO_TABLE;
                  end else begin
                     // install the next fresh table, present and writable
                     dir_we             = 1'b1;
                     dir_wdata.tidx     = TIDX_W'(next_free_ff);
                     dir_wdata.writable = 1'b1;
                     dir_wdata.present  = 1'b1;
                     next_free_in       = next_free_ff + 1'b1;
                     pool_we            = 1'b1;
                     pool_addr = pool_slot(TIDX_W'(next_free_ff), cur_ff.tbl_idx);
                  end
               end

               KIND_UNMAP: begin
                  rsp_push = 1'b1;
                  pool_we  = dir_rd_ff.present;
               end

               KIND_XLATE: begin
                  if (dir_rd_ff.present) begin
                     state_in = WS_POOL;
                  end else begin
                     rsp_push   = 1'b1;
                     rsp.status = STATUS_NOT_MAPPED;
                  end
               end

               KIND_NONE: begin
                  rsp_push = 1'b1;
               end

               default: begin
                  rsp_push = 1'b1;
               end
            endcase
         end

         WS_POOL: begin
            state_in = WS_IDLE;
            rsp_push = 1'b1;
            if (pool_rd_ff.flags[0]) begin
               rsp.addr   = {pool_rd_ff.frame, cur_ff.offset};
               rsp.mapped = 1'b1;
            end else begin
               rsp.status = STATUS_NOT_MAPPED;
            end
         end

         default: begin
            state_in = WS_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= WS_CLEAR;
         clr_ff       <= '0;
         next_free_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         next_free_ff <= next_free_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_mem[dir_waddr] <= dir_wdata;
      end
      dir_rd_ff <= dir_mem[dir_raddr];
   end

   always_ff @(posedge clock) begin
      if (pool_we) begin
         pool_mem[pool_addr] <= pool_wdata;
      end
      pool_rd_ff <= pool_mem[pool_addr];
   end

   `TLPTE_ASSERT(a_free_bound, clock, reset, 1'b1, next_free_ff <= FREE_W'(TABLE_COUNT))
   `TLPTE_ASSERT(a_push_room, clock, reset, rsp_push, !rsp_full)
   `TLPTE_ASSERT_NEXT(a_pop_exec, clock, reset, cmd_pop, state_ff == WS_EXEC)
   `TLPTE_ASSERT_NEXT(a_free_hold, clock, reset, state_ff != WS_EXEC, next_free_ff == $past(next_free_ff))

endmodule

// ===== src/tlpte_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// Result queue
// Two-entry queue that holds finished results until they are popped.
// ----------------------------------------------------------------------------
module tlpte_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tlpte_pkg::rsp_type  push_data,
   output logic                full,
   output logic                empty,
   input  logic                pop,
   output tlpte_pkg::rsp_type  pop_data
);
   import tlpte_pkg::*;

   rsp_type             q_ff [Q_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full     = (count_ff == QCNT_W'(Q_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/two_level_page_table_engine.sv =====
// Two-level page table engine: a 1024-entry page directory over a pool of
// TABLE_COUNT second-level tables (1024 entries each), driven by map, unmap
// and translate requests, one result per request. After reset both stores
// are swept clear, one entry a cycle, through all TABLE_COUNT*1024 pool
// entries (16384 at 16 tables); req_full stays high until the sweep ends.
// Requests then queue in a two-entry command buffer and are walked one at a
// time: the idle state takes a command, the exec state uses the registered
// directory read, and a translate with a present directory entry goes on
// to the registered table-pool read on its single port. Results wait in a
// two-entry queue, so the walker keeps going while they are taken.
// ----------------------------------------------------------------------------
// Two-level page table engine
// Top level: request front end, table walker and result queue.
// ----------------------------------------------------------------------------
module two_level_page_table_engine (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [tlpte_pkg::KIND_W-1:0]     req_kind,
   input  logic [tlpte_pkg::ADDR_W-1:0]     req_virtual_addr,
   input  logic [tlpte_pkg::ADDR_W-1:0]     req_physical_addr,
   input  logic [tlpte_pkg::FLAG_W-1:0]     req_page_flags,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [tlpte_pkg::ADDR_W-1:0]     rsp_translated_addr,
   output logic                             rsp_mapped,
   output logic [tlpte_pkg::STATUS_W-1:0]   rsp_status
);
   import tlpte_pkg::*;

   logic     init_done;
   logic     cmd_valid;
   logic     cmd_pop;
   cmd_type  cmd;
   logic     rsp_full;
   logic     rsp_push;
   rsp_type  rsp_in;
   rsp_type  rsp_head;

   tlpte_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_kind          (req_kind),
      .req_virtual_addr  (req_virtual_addr),
      .req_physical_addr (req_physical_addr),
      .req_page_flags    (req_page_flags),
      .init_done         (init_done),
      .cmd_valid         (cmd_valid),
      .cmd_pop           (cmd_pop),
      .cmd               (cmd)
   );

   tlpte_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .init_done (init_done),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_in)
   );

   tlpte_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rsp_full),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .pop_data  (rsp_head)
   );

   assign rsp_translated_addr = rsp_head.addr;
   assign rsp_mapped          = rsp_head.mapped;
   assign rsp_status          = STATUS_W'(rsp_head.status);

endmodule

// ===== tb/sv/two_level_page_table_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Two-level page table engine testbench
// Drives map, unmap and translate requests through the request queue and
// checks every response against a local walk of a directory and table pool.
// A directed opening covers the address extremes, non-present maps and pool
// exhaustion. Random page-focused sequences follow, with bursty requests, a
// patterned response stall and long response hold-offs.
// ----------------------------------------------------------------------------
module two_level_page_table_engine_tb;
   import tlpte_pkg::*;

   localparam int RANDOM_ITEMS   = 2000;
   localparam int DIR_SET_SIZE   = 20;
   localparam int TBL_SET_SIZE   = 8;
   localparam int DSET_AW        = $clog2(DIR_SET_SIZE);
   localparam int TSET_AW        = $clog2(TBL_SET_SIZE);
   localparam int IDLE_LIMIT     = 60000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int HOLD_CYCLES    = 300;
   localparam int DENTRY_W       = FLAG_W + TIDX_W;
   localparam int TENTRY_W       = FRAME_W + FLAG_W;

   typedef struct {
      op_type            kind;
      logic [ADDR_W-1:0] va;
      logic [ADDR_W-1:0] pa;
      logic [FLAG_W-1:0] flags;
   } page_req_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   logic [KIND_W-1:0]   req_kind = '0;
   logic [ADDR_W-1:0]   req_virtual_addr = '0;
   logic [ADDR_W-1:0]   req_physical_addr = '0;
   logic [FLAG_W-1:0]   req_page_flags = '0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   logic [ADDR_W-1:0]   rsp_translated_addr;
   logic                rsp_mapped;
   logic [STATUS_W-1:0] rsp_status;

   two_level_page_table_engine dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_kind            (req_kind),
      .req_virtual_addr    (req_virtual_addr),
      .req_physical_addr   (req_physical_addr),
      .req_page_flags      (req_page_flags),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_translated_addr (rsp_translated_addr),
      .rsp_mapped          (rsp_mapped),
      .rsp_status          (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the engine's stores
   logic [DENTRY_W-1:0] page_dir [DIR_ENTRIES] = '{default: '0};
   logic [TENTRY_W-1:0] pool_entry [POOL_DEPTH] = '{default: '0};
   int                  tables_used = 0;

   page_req_type pending_reqs [$];
   rsp_type      expected_rsps [$];
   int           mismatch_count = 0;

   logic [DIR_AW-1:0] dir_set [DIR_SET_SIZE];
   logic [TBL_AW-1:0] tbl_set [TBL_SET_SIZE];

   function automatic logic [POOL_AW-1:0] table_slot(logic [DENTRY_W-1:0] dent,
                                                     logic [TBL_AW-1:0] ti);
      return POOL_AW'({dent[FLAG_W +: TIDX_W], ti});
   endfunction

   // Walk both levels for one request, update the shadow stores, return the response.
   function automatic rsp_type walk_tables(page_req_type r);
      rsp_type             res;
      logic [DIR_AW-1:0]   di;
      logic [TBL_AW-1:0]   ti;
      logic [DENTRY_W-1:0] dent;
      logic [TENTRY_W-1:0] tent;
      res.addr   = '0;
      res.mapped = 1'b0;
      res.status = STATUS_DONE;
      di   = r.va[ADDR_W-1 -: DIR_AW];
      ti   = r.va[PAGE_SHIFT +: TBL_AW];
      dent = page_dir[di];
      case (r.kind)
         KIND_MAP: begin
            if (!dent[0]) begin
               if (tables_used >= TABLE_COUNT) begin
                  res.status = STATUS_NO_TABLE;
               end else begin
                  for (int i = 0; i < TBL_ENTRIES; i++)
                     pool_entry[POOL_AW'(tables_used * TBL_ENTRIES + i)] = '0;
                  dent = {tables_used[TIDX_W-1:0], 3'b011};
                  page_dir[di] = dent;
                  tables_used++;
               end
            end
            if (res.status == STATUS_DONE)
               pool_entry[table_slot(dent, ti)] = {r.pa[ADDR_W-1:PAGE_SHIFT], r.flags};
         end
         KIND_UNMAP: begin
            if (dent[0])
               pool_entry[table_slot(dent, ti)] = '0;
         end
         KIND_XLATE: begin
            res.status = STATUS_NOT_MAPPED;
            if (dent[0]) begin
               tent = pool_entry[table_slot(dent, ti)];
               if (tent[0]) begin
                  res.addr   = {tent[FLAG_W +: FRAME_W], r.va[OFFSET_W-1:0]};
                  res.mapped = 1'b1;
                  res.status = STATUS_DONE;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic queue_req(op_type kind, logic [DIR_AW-1:0] di, logic [TBL_AW-1:0] ti,
                            logic [OFFSET_W-1:0] off, logic [ADDR_W-1:0] pa,
                            logic [FLAG_W-1:0] flags);
      page_req_type r;
      r.kind  = kind;
      r.va    = {di, ti, off};
      r.pa    = pa;
      r.flags = flags;
      pending_reqs.push_back(r);
   endtask

   // ---------------- driver ----------------
   page_req_type cur_req;
   int           burst_left = 0;
   int           gap_left = 0;

   always @(posedge clock) begin
      logic push_next;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         push_next = req_push;
         if (req_push && !req_full) begin
            expected_rsps.push_back(walk_tables(cur_req));
            push_next = 1'b0;
         end
         if (!push_next) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_reqs.size() > 0) begin
               cur_req   = pending_reqs.pop_front();
               push_next = 1'b1;
               req_kind          <= cur_req.kind;
               req_virtual_addr  <= cur_req.va;
               req_physical_addr <= cur_req.pa;
               req_page_flags    <= cur_req.flags;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  case ($urandom_range(0, 7))
                     0, 1:    gap_left = 0;
                     2:       gap_left = $urandom_range(10, 30);
                     default: gap_left = $urandom_range(1, 6);
                  endcase
               end
            end
         end
         req_push <= push_next;
      end
   end

   // ---------------- monitor ----------------
   logic [7:0] stall_pattern = 8'hFF;
   int         phase_left = 0;
   int         hold_left = 0;
   int         results_seen = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (expected_rsps.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response: addr=%h mapped=%b status=%0d",
                           rsp_translated_addr, rsp_mapped, rsp_status);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_translated_addr !== want.addr || rsp_mapped !== want.mapped ||
                   rsp_status !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"response %0d mismatch: exp addr=%h mapped=%b status=%0d,",
                               " got addr=%h mapped=%b status=%0d"},
                              results_seen, want.addr, want.mapped, want.status,
                              rsp_translated_addr, rsp_mapped, rsp_status);
               end
            end
            // hold off for a long stretch so the request side backs up
            if (results_seen == 400 || results_seen == 1500)
               hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
               phase_left    = $urandom_range(16, 96);
            end
            phase_left--;
            stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
            rsp_pop <= stall_pattern[0];
         end
      end
   end

   // ---------------- watchdog ----------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("two_level_page_table_engine_tb: errors");
         $finish;
      end
   end

   // ---------------- stimulus and end of test ----------------
   initial begin
      logic [DIR_AW-1:0]   di;
      logic [TBL_AW-1:0]   ti;
      op_type              kind;
      bit                  dup;
      int                  added;
      int                  pick;

      // distinct directory slots; the two extremes come first
      dir_set[0] = '0;
      dir_set[1] = '1;
      for (int i = 2; i < DIR_SET_SIZE; i++) begin
         do begin
            di  = DIR_AW'($urandom_range(1, DIR_ENTRIES - 2));
            dup = 1'b0;
            for (int j = 0; j < i; j++)
               if (dir_set[j] == di) dup = 1'b1;
         end while (dup);
         dir_set[i] = di;
      end
      tbl_set[0] = '0;
      tbl_set[1] = '1;
      for (int i = 2; i < TBL_SET_SIZE; i++)
         tbl_set[i] = TBL_AW'($urandom_range(0, TBL_ENTRIES - 1));

      // directed opening
      queue_req(KIND_XLATE, '0, '0, '0, '0, '0);          // directory entry absent
      queue_req(KIND_UNMAP, '0, '0, '0, '0, '0);          // unmap with absent directory
      queue_req(KIND_MAP,   '0, '0, 12'hABC, '1, 3'd7);
      queue_req(KIND_XLATE, '0, '0, 12'hFFF, '0, '0);
      queue_req(KIND_MAP,   '1, '1, '1, '0, 3'd1);
      queue_req(KIND_XLATE, '1, '1, '0, '1, '1);
      queue_req(KIND_MAP,   '0, 10'd1, '0, $urandom, 3'd6); // written but not present
      queue_req(KIND_XLATE, '0, 10'd1, OFFSET_W'($urandom), '0, '0);
      queue_req(KIND_UNMAP, '0, '0, '1, '1, '1);
      queue_req(KIND_XLATE, '0, '0, 12'd5, '0, '0);
      queue_req(KIND_UNMAP, '0, 10'd2, '0, '0, '0);       // entry already empty
      queue_req(KIND_XLATE, '1, 10'd5, OFFSET_W'($urandom), '0, '0); // empty entry
      queue_req(KIND_NONE,  '1, '1, '1, '1, '1);
      // take every remaining pool table, then one map too many
      for (int i = 2; i <= TABLE_COUNT; i++)
         queue_req(KIND_MAP, dir_set[i],
                   tbl_set[TSET_AW'($urandom_range(0, TBL_SET_SIZE - 1))],
                   OFFSET_W'($urandom), $urandom,
                   FLAG_W'($urandom_range(0, 7)) | 3'd1);

      // random page-focused sequences
      added = 0;
      while (added < RANDOM_ITEMS) begin
         di = ($urandom_range(0, 9) == 0) ?
              DIR_AW'($urandom) : dir_set[DSET_AW'($urandom_range(0, DIR_SET_SIZE - 1))];
         ti = ($urandom_range(0, 6) == 0) ?
              TBL_AW'($urandom) : tbl_set[TSET_AW'($urandom_range(0, TBL_SET_SIZE - 1))];
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            queue_req(KIND_MAP, di, ti, OFFSET_W'($urandom), $urandom,
                      ($urandom_range(0, 3) == 0) ? FLAG_W'($urandom)
                                                  : (FLAG_W'($urandom) | 3'd1));
            queue_req(KIND_XLATE, di, ti, OFFSET_W'($urandom), $urandom, FLAG_W'($urandom));
            added += 2;
            if ($urandom_range(0, 9) < 3) begin
               queue_req(KIND_UNMAP, di, ti, OFFSET_W'($urandom), $urandom,
                         FLAG_W'($urandom));
               queue_req(KIND_XLATE, di, ti, OFFSET_W'($urandom), $urandom,
                         FLAG_W'($urandom));
               added += 2;
            end
         end else begin
            case ($urandom_range(0, 19))
               0:                   kind = KIND_NONE;
               1, 2, 3, 4:          kind = KIND_UNMAP;
               5, 6, 7, 8, 9:       kind = KIND_MAP;
               default:             kind = KIND_XLATE;
            endcase
            queue_req(kind, di, ti, OFFSET_W'($urandom), $urandom, FLAG_W'($urandom));
            added++;
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() > 0 || req_push || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("two_level_page_table_engine_tb: clean");
      else
         $display("two_level_page_table_engine_tb: errors");
      $finish;
   end

endmodule
